// ===== src/avel_pkg.sv =====
`default_nettype none
package avel_pkg;

    // field widths
    localparam int AngleW  = 9;
    localparam int StampW  = 32;
    localparam int SpeedW  = 19;
    localparam int WeightW = 17;

    // internal widths
    localparam int DiffW = AngleW + 2;        // raw angle difference, signed
    localparam int DpW   = 10;                // wrapped angle change, signed
    localparam int QuoW  = 18;                // |dP*1000| and the quotient
    localparam int DivW  = StampW - 1;        // positive time step
    localparam int CntW  = $clog2(QuoW + 1);
    localparam int MulAW = SpeedW;
    localparam int MulBW = WeightW + 1;
    localparam int ProdW = MulAW + MulBW;
    localparam int FracW = 16;

    // constants
    localparam logic [WeightW-1:0] WeightOne = WeightW'(65536);
    localparam int HalfTurn = 180;
    localparam int FullTurn = 360;
    localparam int DegScale = 1000;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MULP,
        S_DIVS,
        S_DIVW,
        S_MULA,
        S_MULB,
        S_FIN,
        S_EMIT
    } t_state;

endpackage
`default_nettype wire

// ===== src/angular_velocity_estimator_unit.sv =====
// Angular speed estimator for a shaft position sensor.
// Input channel: i_in_valid / o_in_stall carries one word of angle_deg and
// stamp_ms. Output channel: o_out_valid / i_out_stall carries one word of
// speed_dps (degrees per second, two's complement) and held for each input.
// Configuration: i_cfg_we writes i_cfg_data into the smoothing weight
// (Q1.16, values above 1.0 saturate to 1.0); write it only while idle.
// Sequence: the first word after reset and any word whose time step is not
// positive go straight to the output load with the held speed. A normal
// word takes one multiply, a restoring divider (one quotient bit per cycle),
// two multiplies through the same multiplier, a truncation step and the
// output load.
// One word is in flight at a time; o_in_stall is high until the result has
// been moved into the output register, so a new word is not taken before
// the last one is through.
// When the receiver stalls, the result holds in the output register and the
// block stops before its final load until the register frees.
// Reset (synchronous, active low) clears the stored angle, time, speed and
// the primed flag and sets the weight to zero.
`default_nettype none
module angular_velocity_estimator_unit (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [avel_pkg::WeightW-1:0]         i_cfg_data,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic [avel_pkg::AngleW-1:0]          i_angle_deg,
    input  wire logic [avel_pkg::StampW-1:0]          i_stamp_ms,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic signed [avel_pkg::SpeedW-1:0]        o_speed_dps,
    output logic                                      o_held
);

    avel_pkg::t_state r_state;
    avel_pkg::t_state n_state;

    logic [avel_pkg::WeightW-1:0]        r_weight;
    logic [avel_pkg::AngleW-1:0]         r_prev_angle;
    logic [avel_pkg::StampW-1:0]         r_prev_stamp;
    logic signed [avel_pkg::SpeedW-1:0]  r_prev_speed;
    logic                                r_primed;
    logic [avel_pkg::AngleW-1:0]         r_angle;
    logic [avel_pkg::StampW-1:0]         r_stamp;
    logic signed [avel_pkg::DpW-1:0]     r_dp;
    logic [avel_pkg::DivW-1:0]           r_dt;
    logic                                r_neg;
    logic signed [avel_pkg::SpeedW-1:0]  r_raw;
    logic signed [avel_pkg::ProdW-1:0]   r_acc;
    logic                                r_held;
    logic                                r_out_valid;
    logic signed [avel_pkg::SpeedW-1:0]  r_out_speed;
    logic                                r_out_held;

    logic                                s_accept;
    logic                                s_out_free;
    logic signed [avel_pkg::DiffW-1:0]   s_diff;
    logic [avel_pkg::DiffW-1:0]          s_mag;
    logic signed [avel_pkg::DpW-1:0]     s_dp;
    logic [avel_pkg::StampW-1:0]         s_dt;
    logic                                s_dt_ok;
    logic [avel_pkg::WeightW-1:0]        s_k;
    logic signed [avel_pkg::MulAW-1:0]   s_mul_a;
    logic signed [avel_pkg::MulBW-1:0]   s_mul_b;
    logic signed [avel_pkg::ProdW-1:0]   s_mul_p;
    logic                                s_div_start;
    logic [avel_pkg::QuoW-1:0]           s_dividend;
    logic signed [avel_pkg::ProdW-1:0]   s_acc_adj;
    logic                                s_div_done;
    logic [avel_pkg::QuoW-1:0]           s_quotient;

    assign s_accept   = i_in_valid && !o_in_stall;
    assign s_out_free = !r_out_valid || !i_out_stall;

    // wrap the angle change to the shorter path
    always_comb begin
        s_diff = $signed({2'b00, i_angle_deg}) - $signed({2'b00, r_prev_angle});
        s_mag  = s_diff[avel_pkg::DiffW-1] ? avel_pkg::DiffW'(-s_diff)
                                           : avel_pkg::DiffW'(s_diff);
        if (s_mag > avel_pkg::DiffW'(avel_pkg::HalfTurn)) begin
            if (s_diff[avel_pkg::DiffW-1]) begin
                s_dp = avel_pkg::DpW'(avel_pkg::DiffW'(avel_pkg::FullTurn) - s_mag);
            end else begin
                s_dp = avel_pkg::DpW'(s_mag - avel_pkg::DiffW'(avel_pkg::FullTurn));
            end
        end else if (s_diff == -avel_pkg::DiffW'(avel_pkg::HalfTurn)) begin
            s_dp = avel_pkg::DpW'(avel_pkg::HalfTurn);
        end else begin
            s_dp = avel_pkg::DpW'(s_diff);
        end
    end

    // time step, valid only when positive as a signed value
    assign s_dt    = i_stamp_ms - r_prev_stamp;
    assign s_dt_ok = (s_dt != '0) && !s_dt[avel_pkg::StampW-1];

    // saturate the weight to 1.0
    assign s_k = r_weight[avel_pkg::WeightW-1] ? avel_pkg::WeightOne : r_weight;

    // shared multiplier
    assign s_mul_p = s_mul_a * s_mul_b;

    // magnitude of dP*1000 for the divider
    assign s_dividend = r_acc[avel_pkg::ProdW-1] ? (~r_acc[avel_pkg::QuoW-1:0] + 1'b1)
                                                 : r_acc[avel_pkg::QuoW-1:0];

    // truncate toward zero on the Q16 shift
    assign s_acc_adj = r_acc + (r_acc[avel_pkg::ProdW-1]
                                ? avel_pkg::ProdW'((1 << avel_pkg::FracW) - 1)
                                : avel_pkg::ProdW'(0));

    avel_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_div_start),
        .i_dividend (s_dividend),
        .i_divisor  (r_dt),
        .o_done     (s_div_done),
        .o_quotient (s_quotient)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            avel_pkg::S_IDLE: begin
                if (s_accept) begin
                    n_state = (r_primed && s_dt_ok) ? avel_pkg::S_MULP : avel_pkg::S_EMIT;
                end
            end
            avel_pkg::S_MULP: n_state = avel_pkg::S_DIVS;
            avel_pkg::S_DIVS: n_state = avel_pkg::S_DIVW;
            avel_pkg::S_DIVW: begin
                if (s_div_done) begin
                    n_state = avel_pkg::S_MULA;
                end
            end
            avel_pkg::S_MULA: n_state = avel_pkg::S_MULB;
            avel_pkg::S_MULB: n_state = avel_pkg::S_FIN;
            avel_pkg::S_FIN:  n_state = avel_pkg::S_EMIT;
            avel_pkg::S_EMIT: begin
                if (s_out_free) begin
                    n_state = avel_pkg::S_IDLE;
                end
            end
            default: n_state = avel_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_stall  = 1'b1;
        s_div_start = 1'b0;
        s_mul_a     = '0;
        s_mul_b     = '0;
        unique case (r_state)
            avel_pkg::S_IDLE: o_in_stall = 1'b0;
            avel_pkg::S_MULP: begin
                s_mul_a = avel_pkg::MulAW'(r_dp);
                s_mul_b = avel_pkg::MulBW'(avel_pkg::DegScale);
            end
            avel_pkg::S_DIVS: s_div_start = 1'b1;
            avel_pkg::S_MULA: begin
                s_mul_a = r_prev_speed;
                s_mul_b = $signed({1'b0, s_k});
            end
            avel_pkg::S_MULB: begin
                s_mul_a = r_raw;
                s_mul_b = $signed({1'b0, avel_pkg::WeightOne - s_k});
            end
            default: begin
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= avel_pkg::S_IDLE;
            r_weight     <= '0;
            r_prev_angle <= '0;
            r_prev_stamp <= '0;
            r_prev_speed <= '0;
            r_primed     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_weight <= i_cfg_data;
            end
            // priming word stores the sample only
            if (r_state == avel_pkg::S_IDLE && s_accept && !r_primed) begin
                r_prev_angle <= i_angle_deg;
                r_prev_stamp <= i_stamp_ms;
                r_primed     <= 1'b1;
            end
            // commit the new estimate
            if (r_state == avel_pkg::S_FIN) begin
                r_prev_speed <= s_acc_adj[avel_pkg::FracW+avel_pkg::SpeedW-1:avel_pkg::FracW];
                r_prev_angle <= r_angle;
                r_prev_stamp <= r_stamp;
            end
            // output register handshake
            if (r_state == avel_pkg::S_EMIT && s_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            avel_pkg::S_IDLE: begin
                r_angle <= i_angle_deg;
                r_stamp <= i_stamp_ms;
                r_dp    <= s_dp;
                r_dt    <= s_dt[avel_pkg::DivW-1:0];
                r_held  <= 1'b1;
            end
            avel_pkg::S_MULP: r_acc <= s_mul_p;
            avel_pkg::S_DIVS: r_neg <= r_acc[avel_pkg::ProdW-1];
            avel_pkg::S_DIVW: begin
                r_raw <= r_neg ? -$signed({1'b0, s_quotient}) : $signed({1'b0, s_quotient});
            end
            avel_pkg::S_MULA: r_acc <= s_mul_p;
            avel_pkg::S_MULB: r_acc <= r_acc + s_mul_p;
            avel_pkg::S_FIN:  r_held <= 1'b0;
            avel_pkg::S_EMIT: begin
                if (s_out_free) begin
                    r_out_speed <= r_prev_speed;
                    r_out_held  <= r_held;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_speed_dps = r_out_speed;
    assign o_held      = r_out_held;

endmodule
`default_nettype wire

// ===== src/avel_divider.sv =====
`default_nettype none
module avel_divider (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [avel_pkg::QuoW-1:0]         i_dividend,
    input  wire logic [avel_pkg::DivW-1:0]         i_divisor,
    output logic                                   o_done,
    output logic [avel_pkg::QuoW-1:0]              o_quotient
);

    logic [avel_pkg::DivW-1:0] r_rem;
    logic [avel_pkg::DivW-1:0] r_div;
    logic [avel_pkg::QuoW-1:0] r_quo;
    logic [avel_pkg::CntW-1:0] r_cnt;
    logic                      r_busy;
    logic                      r_done;

    logic [avel_pkg::DivW:0]   s_trial;
    logic [avel_pkg::DivW:0]   s_diff;
    logic                      s_ge;

    // one restoring step: shift in the next dividend bit, subtract when it fits
    always_comb begin
        s_trial = {r_rem, r_quo[avel_pkg::QuoW-1]};
        s_ge    = (s_trial >= {1'b0, r_div});
        s_diff  = s_trial - {1'b0, r_div};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= avel_pkg::CntW'(avel_pkg::QuoW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == avel_pkg::CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= s_ge ? s_diff[avel_pkg::DivW-1:0] : s_trial[avel_pkg::DivW-1:0];
            r_quo <= {r_quo[avel_pkg::QuoW-2:0], s_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire
